/* hw/rtl/console_cpu_bus_ppu_register_port_defines.svh */
// Assertion macros for the checker file.
`ifndef CONSOLE_CPU_BUS_PPU_REGISTER_PORT_DEFINES_SVH
`define CONSOLE_CPU_BUS_PPU_REGISTER_PORT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CCBP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CCBP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ccbp_pkg.sv */
`default_nettype none

package ccbp_pkg;

   // work RAM, mirrored across the low 8 KiB of the bus
   localparam int RAM_DEPTH       = 2048;
   localparam int RAM_WIDTH       = 8;
   localparam int RAM_INDEX_WIDTH = $clog2(RAM_DEPTH);
   localparam int RAM_WINDOW      = 8192;
   localparam int RAM_FOLDS       = (RAM_WINDOW - 1) / RAM_DEPTH;

   // bus decode limits
   localparam logic [15:0] RAM_LIMIT = 16'h2000;
   localparam logic [15:0] PPU_LIMIT = 16'h4000;
   localparam logic [15:0] IO_LIMIT  = 16'h4020;

   // v[13:8] at or above this is palette space
   localparam logic [5:0] PALETTE_PAGE = 6'h3F;

   localparam int CTRL_INCREMENT_BIT = 2;

   localparam int RSP_QUEUE_DEPTH = 3;
   localparam int RSP_LEVEL_WIDTH = $clog2(RSP_QUEUE_DEPTH + 1);

   localparam logic [1:0] ACTION_READ         = 2'd0;
   localparam logic [1:0] ACTION_WRITE        = 2'd1;
   localparam logic [1:0] ACTION_VBLANK_START = 2'd2;
   localparam logic [1:0] ACTION_VBLANK_END   = 2'd3;

   localparam logic [1:0] TARGET_RAM  = 2'd0;
   localparam logic [1:0] TARGET_PPU  = 2'd1;
   localparam logic [1:0] TARGET_IO   = 2'd2;
   localparam logic [1:0] TARGET_CART = 2'd3;

   localparam logic [2:0] REG_CONTROL  = 3'd0;
   localparam logic [2:0] REG_MASK     = 3'd1;
   localparam logic [2:0] REG_STATUS   = 3'd2;
   localparam logic [2:0] REG_OAM_ADDR = 3'd3;
   localparam logic [2:0] REG_OAM_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL   = 3'd5;
   localparam logic [2:0] REG_ADDRESS  = 3'd6;
   localparam logic [2:0] REG_DATA     = 3'd7;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [7:0]  vram_read_data;
      logic [7:0]  cart_read_data;
      logic [6:0]  status_low;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [1:0]  target;
      logic        vram_write;
      logic [14:0] vram_address;
      logic [7:0]  vram_write_data;
      logic [7:0]  control_value;
      logic [7:0]  mask_value;
      logic [14:0] temp_address;
      logic [2:0]  fine_scroll_x;
      logic [7:0]  sprite_table_address;
   } rsp_payload_type;

   typedef struct packed {
      logic                       read;
      logic                       write;
      logic [RAM_INDEX_WIDTH-1:0] index;
      logic [RAM_WIDTH-1:0]       data;
   } ram_access_type;

   // Mirror a low-window address onto the RAM; at most three folds.
   function automatic logic [RAM_INDEX_WIDTH-1:0] ram_index(input logic [12:0] addr);
      logic [13:0] folded;
      folded = {1'b0, addr};
      for (int i = 0; i < RAM_FOLDS; i++) begin
         if (folded >= 14'(RAM_DEPTH)) folded = folded - 14'(RAM_DEPTH);
      end
      return folded[RAM_INDEX_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ccbp_ram.sv */
`default_nettype none

module ccbp_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_index,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_index,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_index] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data <= mem[rd_index];
   end

endmodule

`default_nettype wire

/* hw/rtl/ccbp_ppu_regs.sv */
`default_nettype none

module ccbp_ppu_regs
   import ccbp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire req_payload_type req,
   output rsp_payload_type      rsp,
   output ram_access_type       ram_access
);

   logic [7:0]  read_buffer_ff, read_buffer_in;
   logic [7:0]  control_ff, control_in;
   logic [7:0]  mask_ff, mask_in;
   logic        vblank_ff, vblank_in;
   logic [7:0]  oam_addr_ff, oam_addr_in;
   logic [7:0]  oam_data_ff, oam_data_in;
   logic [14:0] scroll_temp_ff, scroll_temp_in;
   logic [14:0] vram_pointer_ff, vram_pointer_in;
   logic [2:0]  fine_x_ff, fine_x_in;
   logic        first_write_ff, first_write_in;

   logic [14:0] pointer_stepped;
   logic        is_read;
   logic [2:0]  sel;

   assign pointer_stepped = vram_pointer_ff +
                            (control_ff[CTRL_INCREMENT_BIT] ? 15'd32 : 15'd1);
   assign is_read = (req.action == ACTION_READ);
   assign sel     = req.address[2:0];

   always_comb begin
      read_buffer_in  = read_buffer_ff;
      control_in      = control_ff;
      mask_in         = mask_ff;
      vblank_in       = vblank_ff;
      oam_addr_in     = oam_addr_ff;
      oam_data_in     = oam_data_ff;
      scroll_temp_in  = scroll_temp_ff;
      vram_pointer_in = vram_pointer_ff;
      fine_x_in       = fine_x_ff;
      first_write_in  = first_write_ff;
      rsp             = '0;
      ram_access      = '0;
      rsp.vram_address = vram_pointer_ff;

      if (accept) begin
         case (req.action)
            ACTION_VBLANK_START: vblank_in = 1'b1;
            ACTION_VBLANK_END:   vblank_in = 1'b0;
            default: begin
               if (req.address < RAM_LIMIT) begin
                  rsp.target       = TARGET_RAM;
                  ram_access.read  = is_read;
                  ram_access.write = !is_read;
                  ram_access.index = ram_index(req.address[12:0]);
                  ram_access.data  = req.write_data;
               end else if (req.address < PPU_LIMIT) begin
                  rsp.target = TARGET_PPU;
                  if (is_read) begin
                     case (sel)
                        REG_CONTROL:  rsp.read_data = control_ff;
                        REG_MASK:     rsp.read_data = mask_ff;
                        REG_STATUS: begin
                           rsp.read_data  = {vblank_ff, req.status_low};
                           vblank_in      = 1'b0;
                           first_write_in = 1'b1;
                        end
                        REG_OAM_DATA: rsp.read_data = oam_data_ff;
                        REG_DATA: begin
                           // palette reads bypass the delayed buffer
                           read_buffer_in  = req.vram_read_data;
                           rsp.read_data   = (vram_pointer_ff[13:8] == PALETTE_PAGE) ?
                                             req.vram_read_data : read_buffer_ff;
                           vram_pointer_in = pointer_stepped;
                        end
                        default: rsp.read_data = '0;
                     endcase
                  end else begin
                     case (sel)
                        REG_CONTROL:  control_in  = req.write_data;
                        REG_MASK:     mask_in     = req.write_data;
                        REG_OAM_ADDR: oam_addr_in = req.write_data;
                        REG_OAM_DATA: begin
                           oam_data_in = req.write_data;
                           oam_addr_in = oam_addr_ff + 8'd1;
                        end
                        REG_SCROLL: begin
                           if (first_write_ff) begin
                              scroll_temp_in = {scroll_temp_ff[14:5], req.write_data[7:3]};
                              fine_x_in      = req.write_data[2:0];
                           end else begin
                              scroll_temp_in = {req.write_data[2:0], scroll_temp_ff[11:10],
                                                req.write_data[7:3], scroll_temp_ff[4:0]};
                           end
                           first_write_in = !first_write_ff;
                        end
                        REG_ADDRESS: begin
                           if (first_write_ff) begin
                              scroll_temp_in = {1'b0, req.write_data[5:0],
                                                scroll_temp_ff[7:0]};
                           end else begin
                              scroll_temp_in  = {scroll_temp_ff[14:8], req.write_data};
                              vram_pointer_in = {scroll_temp_ff[14:8], req.write_data};
                           end
                           first_write_in = !first_write_ff;
                        end
                        REG_DATA: begin
                           rsp.vram_write      = 1'b1;
                           rsp.vram_write_data = req.write_data;
                           vram_pointer_in     = pointer_stepped;
                        end
                        default: ;
                     endcase
                  end
               end else if (req.address < IO_LIMIT) begin
                  rsp.target = TARGET_IO;
               end else begin
                  rsp.target = TARGET_CART;
                  if (is_read) rsp.read_data = req.cart_read_data;
               end
            end
         endcase
      end

      rsp.control_value        = control_in;
      rsp.mask_value           = mask_in;
      rsp.temp_address         = scroll_temp_in;
      rsp.fine_scroll_x        = fine_x_in;
      rsp.sprite_table_address = oam_addr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_buffer_ff  <= '0;
         control_ff      <= '0;
         mask_ff         <= '0;
         vblank_ff       <= 1'b0;
         oam_addr_ff     <= '0;
         oam_data_ff     <= '0;
         scroll_temp_ff  <= '0;
         vram_pointer_ff <= '0;
         fine_x_ff       <= '0;
         first_write_ff  <= 1'b1;
      end else begin
         read_buffer_ff  <= read_buffer_in;
         control_ff      <= control_in;
         mask_ff         <= mask_in;
         vblank_ff       <= vblank_in;
         oam_addr_ff     <= oam_addr_in;
         oam_data_ff     <= oam_data_in;
         scroll_temp_ff  <= scroll_temp_in;
         vram_pointer_ff <= vram_pointer_in;
         fine_x_ff       <= fine_x_in;
         first_write_ff  <= first_write_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/ccbp_rsp_queue.sv */
`default_nettype none

module ccbp_rsp_queue
   import ccbp_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire rsp_payload_type            push_data,
   input  wire logic                       out_stall,
   output logic                            out_valid,
   output rsp_payload_type                 out_data,
   output logic [RSP_LEVEL_WIDTH-1:0]      level
);

   localparam int PTR_WIDTH = $clog2(RSP_QUEUE_DEPTH);
   localparam logic [PTR_WIDTH-1:0] LAST = PTR_WIDTH'(RSP_QUEUE_DEPTH - 1);

   rsp_payload_type entries [RSP_QUEUE_DEPTH];

   logic [PTR_WIDTH-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [RSP_LEVEL_WIDTH-1:0] level_ff, level_in;
   logic                       pop;

   assign out_valid = (level_ff != '0);
   assign out_data  = entries[rd_ptr_ff];
   assign level     = level_ff;
   assign pop       = out_valid && !out_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      level_in = level_ff + 1'b1;
      else if (pop && !push) level_in = level_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

/* hw/rtl/console_cpu_bus_ppu_register_port.sv */
// CPU bus port with work RAM and the eight PPU registers. One request is taken
// every cycle while req_stall is low; its response passes through the registered
// read of the work RAM and a three-entry response queue. req_stall is high in reset
// and otherwise rises only once the queue and the RAM read stage together hold
// three responses, so rsp_stall never reaches req_stall combinationally. Register
// updates take effect at acceptance, RAM writes land before any later read, and
// work RAM contents are undefined until written (no clearing pass after reset).
`default_nettype none

module console_cpu_bus_ppu_register_port
   import ccbp_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload
);

   logic                       accept;
   rsp_payload_type            ppu_rsp;
   ram_access_type             ram_access;
   logic [RAM_WIDTH-1:0]       ram_rd_data;
   logic [RSP_LEVEL_WIDTH-1:0] queue_level;
   logic [RSP_LEVEL_WIDTH:0]   occupancy;

   logic                       s1_valid_ff;
   logic                       s1_ram_read_ff;
   rsp_payload_type            s1_payload_ff;
   rsp_payload_type            s1_merged;

   assign occupancy = {1'b0, queue_level} + (RSP_LEVEL_WIDTH + 1)'(s1_valid_ff);
   assign req_stall = reset || (occupancy >= (RSP_LEVEL_WIDTH + 1)'(RSP_QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   ccbp_ppu_regs u_ppu_regs (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_payload),
      .rsp        (ppu_rsp),
      .ram_access (ram_access)
   );

   ccbp_ram #(
      .DEPTH (RAM_DEPTH),
      .WIDTH (RAM_WIDTH)
   ) u_ram (
      .clock    (clock),
      .wr_en    (ram_access.write),
      .wr_index (ram_access.index),
      .wr_data  (ram_access.data),
      .rd_en    (ram_access.read),
      .rd_index (ram_access.index),
      .rd_data  (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_payload_ff  <= ppu_rsp;
         s1_ram_read_ff <= ram_access.read;
      end
   end

   always_comb begin
      s1_merged = s1_payload_ff;
      if (s1_ram_read_ff) s1_merged.read_data = ram_rd_data;
   end

   ccbp_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (s1_merged),
      .out_stall (rsp_stall),
      .out_valid (rsp_valid),
      .out_data  (rsp_payload),
      .level     (queue_level)
   );

endmodule

`default_nettype wire

/* hw/rtl/ccbp_checker.sv */
`default_nettype none
`include "console_cpu_bus_ppu_register_port_defines.svh"

module ccbp_checker
   import ccbp_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   `CCBP_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
   `CCBP_ASSERT_NEXT(a_rsp_payload_holds, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload), "stalled response changed")
   `CCBP_ASSERT_IMPLY(a_vram_write_target, clock, reset, rsp_valid && rsp_payload.vram_write, rsp_payload.target == TARGET_PPU && rsp_payload.read_data == 8'd0, "video write outside register space")
   `CCBP_ASSERT_IMPLY(a_io_hole_reads_zero, clock, reset, rsp_valid && rsp_payload.target == TARGET_IO, rsp_payload.read_data == 8'd0 && !rsp_payload.vram_write, "io hole returned data")
   `CCBP_ASSERT_IMPLY(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid, "response straight after reset")

endmodule

bind console_cpu_bus_ppu_register_port ccbp_checker u_ccbp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
